[rtl/cbc_pkg.sv]
// Shared types and constants for the cartridge bank controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

   // Field widths fixed by the bus and by the banking scheme
   localparam int ADDR_W       = 16;
   localparam int DATA_W       = 8;
   localparam int ROM_ADDR_W   = 21;
   localparam int LOW_BANK_W   = 5;
   localparam int HIGH_BANK_W  = 2;
   localparam int ROM_LOG2_W   = 5;
   localparam int RAM_SEL_W    = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 5;
   localparam int RAM_OFFSET_W = 15;   // bank (2) plus 13 offset bits

   // Defaults handed to the top-level parameters
   localparam int RAM_BYTES_DEFAULT     = 32768;
   localparam int ROM_ADDR_BITS_DEFAULT = 21;

   // Smallest ROM the mask ever shrinks to
   localparam logic [ROM_LOG2_W-1:0] ROM_MIN_LOG2 = 5'd15;

   // Control register regions, selected by address bits 14..13
   localparam logic [1:0] CTRL_RAM_ENABLE = 2'b00;
   localparam logic [1:0] CTRL_LOW_BANK   = 2'b01;
   localparam logic [1:0] CTRL_HIGH_BANK  = 2'b10;
   localparam logic [1:0] CTRL_BANK_MODE  = 2'b11;

   // Value of the low data nibble that enables RAM
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_SIZE_LOG2 = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_SIZE_SEL  = 1'b1;

   // RAM size selections and their log2 byte counts
   localparam logic [RAM_SEL_W-1:0] RAM_SEL_NONE = 2'd0;
   localparam logic [RAM_SEL_W-1:0] RAM_SEL_2K   = 2'd1;
   localparam logic [RAM_SEL_W-1:0] RAM_SEL_8K   = 2'd2;
   localparam logic [RAM_SEL_W-1:0] RAM_SEL_32K  = 2'd3;
   localparam logic [3:0] RAM_LOG2_2K  = 4'd11;
   localparam logic [3:0] RAM_LOG2_8K  = 4'd13;
   localparam logic [3:0] RAM_LOG2_32K = 4'd15;

   // Access kinds
   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic                  rom_hit;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic [DATA_W-1:0]     read_data;
   } rsp_type;

   // Control state as seen by the datapath
   typedef struct packed {
      logic                   ram_enabled;
      logic [LOW_BANK_W-1:0]  low_bank;
      logic [HIGH_BANK_W-1:0] high_bank;
      logic                   bank_mode;
      logic [ROM_LOG2_W-1:0]  rom_size_log2;
      logic [RAM_SEL_W-1:0]   ram_size_sel;
   } ctrl_type;

endpackage

`default_nettype wire

[rtl/cbc_ctrl.sv]
// Banking control registers and configuration registers.
// Depends on cbc_pkg for the region codes and the ctrl_type struct.
`timescale 1ns / 1ps
`default_nettype none

module cbc_ctrl
   import cbc_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_accept,
   input  req_type                      req_item,
   input  wire                          csr_write_enable,
   input  wire  [CSR_INDEX_W-1:0]       csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_write_data,
   output ctrl_type                     ctrl
);

   ctrl_type ctrl_ff;
   ctrl_type ctrl_in;
   logic     ctrl_write;

   // Only accepted writes below 0x8000 touch the banking registers
   assign ctrl_write = req_accept && (req_item.action == ACTION_WRITE) &&
                       !req_item.address[ADDR_W-1];

   // Next value of the control registers
   always_comb begin
      ctrl_in = ctrl_ff;
      if (ctrl_write) begin
         unique case (req_item.address[14:13])
            CTRL_RAM_ENABLE: begin
               ctrl_in.ram_enabled = (req_item.write_data[3:0] == RAM_ENABLE_KEY);
            end
            CTRL_LOW_BANK: begin
               // bank zero maps to bank one
               if (req_item.write_data[LOW_BANK_W-1:0] == '0) begin
                  ctrl_in.low_bank = LOW_BANK_W'(1);
               end else begin
                  ctrl_in.low_bank = req_item.write_data[LOW_BANK_W-1:0];
               end
            end
            CTRL_HIGH_BANK: begin
               ctrl_in.high_bank = req_item.write_data[HIGH_BANK_W-1:0];
            end
            CTRL_BANK_MODE: begin
               ctrl_in.bank_mode = req_item.write_data[0];
            end
            default: begin
               ctrl_in = ctrl_ff;
            end
         endcase
      end
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROM_SIZE_LOG2: begin
               ctrl_in.rom_size_log2 = csr_write_data[ROM_LOG2_W-1:0];
            end
            CSR_RAM_SIZE_SEL: begin
               ctrl_in.ram_size_sel = csr_write_data[RAM_SEL_W-1:0];
            end
            default: begin
               ctrl_in.ram_size_sel = ctrl_ff.ram_size_sel;
            end
         endcase
      end
   end

   // Hold the registers, load reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.ram_enabled   <= 1'b0;
         ctrl_ff.low_bank      <= LOW_BANK_W'(1);
         ctrl_ff.high_bank     <= '0;
         ctrl_ff.bank_mode     <= 1'b0;
         ctrl_ff.rom_size_log2 <= ROM_MIN_LOG2;
         ctrl_ff.ram_size_sel  <= RAM_SEL_NONE;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

endmodule

`default_nettype wire

[rtl/cbc_ram.sv]
// Single-port cartridge RAM with a registered read port.
// Depends on cbc_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module cbc_ram
   import cbc_pkg::*;
#(
   parameter int DEPTH = RAM_BYTES_DEFAULT,
   parameter int AW    = $clog2(RAM_BYTES_DEFAULT)
) (
   input  wire               clock,
   input  wire               write_enable,
   input  wire               read_enable,
   input  wire  [AW-1:0]     addr,
   input  wire  [DATA_W-1:0] write_data,
   output logic [DATA_W-1:0] read_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] read_data_ff;

   // Write the byte
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[addr] <= write_data;
      end
   end

   // Read the byte; hold the last read otherwise
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

[rtl/cartridge_bank_controller_unit.sv]
// Cartridge bank controller: bus access decode, ROM mapping and banked RAM.
// Depends on cbc_pkg, cbc_ctrl and cbc_ram.
//
// Usage:
//   req_* carries one bus access per item (read or write, address, byte).
//   rsp_* returns one result per item: ROM hit and mapped ROM address, or
//   the RAM byte, or zeros. Results come back in order, one per item.
//   csr_* writes the ROM size (index 0) and RAM size (index 1) while idle.
// Timing and throughput:
//   A result is valid in the cycle after its item is accepted. One item is
//   taken per cycle while rsp_ready is high: the RAM read is issued at
//   acceptance and its data is registered by the single RAM port.
// Stall:
//   While rsp_ready is low the result register and the RAM read data hold,
//   and req_ready drops until the waiting result is taken.
// Reset:
//   Synchronous, active high. Clears the result stage and loads the banking
//   registers (RAM disabled, low bank 1, high bank 0, mode 0, ROM 32 KB,
//   no RAM). RAM contents are not cleared and read as unknown until written.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_controller_unit
   import cbc_pkg::*;
#(
   parameter int RAM_BYTES     = RAM_BYTES_DEFAULT,
   parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output rsp_type                 rsp_data,
   input  wire                     csr_write_enable,
   input  wire  [CSR_INDEX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_write_data
);

   localparam int RamAw = $clog2(RAM_BYTES);
   localparam logic [3:0] RamLog2 = 4'(RamAw);
   localparam logic [ROM_LOG2_W-1:0] RomMaxLog2 = ROM_LOG2_W'(ROM_ADDR_BITS);

   ctrl_type ctrl;
   logic     req_accept;

   logic                    ram_region;
   logic                    ram_usable;
   logic                    ram_access;
   logic [3:0]              ram_sel_log2;
   logic [3:0]              ram_log2;
   logic [RAM_OFFSET_W-1:0] ram_mask;
   logic [RAM_OFFSET_W-1:0] ram_offset;
   logic [HIGH_BANK_W-1:0]  ram_bank;
   logic                    ram_we;
   logic                    ram_re;
   logic [DATA_W-1:0]       ram_rdata;

   logic                    rom_read;
   logic [ROM_LOG2_W-1:0]   rom_log2;
   logic [ROM_ADDR_W-1:0]   rom_mask;
   logic [6:0]              rom_bank;
   logic [ROM_ADDR_W-1:0]   rom_addr;

   logic                    s1_valid_ff,    s1_valid_in;
   logic                    s1_rom_hit_ff,  s1_rom_hit_in;
   logic [ROM_ADDR_W-1:0]   s1_rom_addr_ff, s1_rom_addr_in;
   logic                    s1_ram_read_ff, s1_ram_read_in;

   // Take an item when the result stage is empty or being drained
   assign req_ready  = !s1_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   cbc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_accept       (req_accept),
      .req_item         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ctrl             (ctrl)
   );

   // Size the RAM mask from the selection, capped by the built depth
   always_comb begin
      case (ctrl.ram_size_sel)
         RAM_SEL_2K:  ram_sel_log2 = RAM_LOG2_2K;
         RAM_SEL_8K:  ram_sel_log2 = RAM_LOG2_8K;
         RAM_SEL_32K: ram_sel_log2 = RAM_LOG2_32K;
         default:     ram_sel_log2 = '0;
      endcase
      ram_log2 = (ram_sel_log2 > RamLog2) ? RamLog2 : ram_sel_log2;
      ram_mask = RAM_OFFSET_W'((16'd1 << ram_log2) - 16'd1);
   end

   // Decode the RAM access
   assign ram_region = (req_data.address[15:13] == 3'b101);
   assign ram_usable = ctrl.ram_enabled && (ctrl.ram_size_sel != RAM_SEL_NONE);
   assign ram_access = req_accept && ram_region && ram_usable;
   assign ram_bank   = ctrl.bank_mode ? ctrl.high_bank : '0;
   assign ram_offset = {ram_bank, req_data.address[12:0]} & ram_mask;
   assign ram_we     = ram_access && (req_data.action == ACTION_WRITE);
   assign ram_re     = ram_access && (req_data.action == ACTION_READ);

   cbc_ram #(
      .DEPTH (RAM_BYTES),
      .AW    (RamAw)
   ) u_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .read_enable  (ram_re),
      .addr         (ram_offset[RamAw-1:0]),
      .write_data   (req_data.write_data),
      .read_data    (ram_rdata)
   );

   // Map the ROM read: clamp the size, pick the bank, mask the address
   always_comb begin
      if (ctrl.rom_size_log2 < ROM_MIN_LOG2) begin
         rom_log2 = ROM_MIN_LOG2;
      end else if (ctrl.rom_size_log2 > RomMaxLog2) begin
         rom_log2 = RomMaxLog2;
      end else begin
         rom_log2 = ctrl.rom_size_log2;
      end
      rom_mask = ROM_ADDR_W'((22'd1 << rom_log2) - 22'd1);
      if (req_data.address[14]) begin
         rom_bank = {ctrl.high_bank, ctrl.low_bank};
      end else if (ctrl.bank_mode) begin
         rom_bank = {ctrl.high_bank, 5'd0};
      end else begin
         rom_bank = '0;
      end
      rom_addr = {rom_bank, req_data.address[13:0]} & rom_mask;
   end

   assign rom_read = (req_data.action == ACTION_READ) && !req_data.address[15];

   // Advance the result stage on acceptance, drop it when taken
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_rom_hit_in  = s1_rom_hit_ff;
      s1_rom_addr_in = s1_rom_addr_ff;
      s1_ram_read_in = s1_ram_read_ff;
      if (rsp_valid && rsp_ready) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in    = 1'b1;
         s1_rom_hit_in  = rom_read;
         s1_rom_addr_in = rom_read ? rom_addr : '0;
         s1_ram_read_in = ram_re;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_rom_hit_ff  <= s1_rom_hit_in;
      s1_rom_addr_ff <= s1_rom_addr_in;
      s1_ram_read_ff <= s1_ram_read_in;
   end

   // Drive the result
   assign rsp_valid            = s1_valid_ff;
   assign rsp_data.rom_hit     = s1_rom_hit_ff;
   assign rsp_data.rom_address = s1_rom_addr_ff;
   assign rsp_data.read_data   = s1_ram_read_ff ? ram_rdata : '0;

   // A write item always answers with all fields zero in the next cycle
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.action == ACTION_WRITE)) |=>
         (rsp_valid && (rsp_data == '0)))
      else $error("write item did not produce an all-zero result");

   // The low bank register never holds zero
   a_low_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctrl.low_bank != '0)
      else $error("low bank register holds zero");

   // A ROM hit never carries RAM data
   a_rom_hit_no_ram: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rom_hit) |-> !s1_ram_read_ff)
      else $error("ROM hit flagged together with a RAM read");

   // No RAM port activity while a result stalls
   a_ram_idle_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> (!ram_we && !ram_re))
      else $error("RAM accessed while the result stage is stalled");

endmodule

`default_nettype wire
